### rtl/posting_list_intersection_macros.svh
// ----------------------------------------------------------------------------
// posting_list_intersection_macros
// Assertion macros used by the posting list intersection sequencer (pli_seq).
// ----------------------------------------------------------------------------
`ifndef POSTING_LIST_INTERSECTION_MACROS_SVH
`define POSTING_LIST_INTERSECTION_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define PLI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pli: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pli: next-cycle check failed");

`else

`define PLI_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants, op codes and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int DOC_ID_W          = 32;
  localparam int OP_W              = 2;
  localparam int LIST_CAPACITY_DEF = 64;
  localparam int ID_WIDTH_DEF      = 32;

  localparam logic [OP_W-1:0] OP_APPEND_A  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_APPEND_B  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_INTERSECT = OP_W'(2);

  typedef struct packed {
    logic                valid;
    logic [DOC_ID_W-1:0] match_id;
    logic                is_empty;
    logic                last;
    logic                overflowed;
  } pli_res_t;

endpackage

`default_nettype wire

### rtl/pli_in_if.sv
// ----------------------------------------------------------------------------
// pli_in_if
// Input channel: op and document id, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pli_in_if;
  import pli_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [DOC_ID_W-1:0] doc_id;

  modport source (output valid, output op, output doc_id, input ready);
  modport sink   (input valid, input op, input doc_id, output ready);
endinterface

`default_nettype wire

### rtl/pli_out_if.sv
// ----------------------------------------------------------------------------
// pli_out_if
// Result channel: matched id with empty, last and overflow flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface pli_out_if;
  import pli_pkg::*;

  logic                valid;
  logic                ready;
  logic [DOC_ID_W-1:0] match_id;
  logic                is_empty;
  logic                last;
  logic                overflowed;

  modport source (output valid, output match_id, output is_empty, output last,
                  output overflowed, input ready);
  modport sink   (input valid, input match_id, input is_empty, input last,
                  input overflowed, output ready);
endinterface

`default_nettype wire

### rtl/pli_list_ram.sv
// ----------------------------------------------------------------------------
// pli_list_ram
// One list store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_list_ram #(
  parameter int DEPTH = pli_pkg::LIST_CAPACITY_DEF,
  parameter int WIDTH = pli_pkg::ID_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/pli_seq.sv
// ----------------------------------------------------------------------------
// pli_seq
// Sequencer: appends, in-place insertion sort of each list and the merge;
// the sort and the merge share one magnitude comparator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "posting_list_intersection_macros.svh"

module pli_seq #(
  parameter int LIST_CAPACITY = pli_pkg::LIST_CAPACITY_DEF,
  parameter int ID_WIDTH      = pli_pkg::ID_WIDTH_DEF,
  localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1,
  localparam int CW = $clog2(LIST_CAPACITY + 1),
  localparam int SW = (ID_WIDTH < pli_pkg::DOC_ID_W) ? ID_WIDTH : pli_pkg::DOC_ID_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [pli_pkg::OP_W-1:0]     in_op_i,
  input  logic [pli_pkg::DOC_ID_W-1:0] in_doc_id_i,
  output logic                         in_ready_o,
  input  logic                         out_free_i,
  output pli_pkg::pli_res_t            res_o,
  output logic                         a_we_o,
  output logic [AW-1:0]                a_waddr_o,
  output logic [SW-1:0]                a_wdata_o,
  output logic                         a_re_o,
  output logic [AW-1:0]                a_raddr_o,
  input  logic [SW-1:0]                a_rdata_i,
  output logic                         b_we_o,
  output logic [AW-1:0]                b_waddr_o,
  output logic [SW-1:0]                b_wdata_o,
  output logic                         b_re_o,
  output logic [AW-1:0]                b_raddr_o,
  input  logic [SW-1:0]                b_rdata_i
);
  import pli_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_KEY,
    ST_SORT_KEYW,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_MRG_RD,
    ST_MRG_CMP,
    ST_FLUSH
  } state_e;

  localparam logic [CW-1:0] Cap = CW'(LIST_CAPACITY);
  localparam logic [CW-1:0] Two = CW'(2);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_a_q, cnt_a_d;
  logic [CW-1:0] cnt_b_q, cnt_b_d;
  logic          ovf_q, ovf_d;
  logic          sel_b_q, sel_b_d;
  logic [CW-1:0] i_q, i_d;
  logic [AW-1:0] j_q, j_d;
  logic [SW-1:0] key_q, key_d;
  logic [CW-1:0] ia_q, ia_d;
  logic [CW-1:0] ib_q, ib_d;
  logic          pend_vld_q, pend_vld_d;
  logic [SW-1:0] pend_id_q, pend_id_d;

  logic [CW-1:0] n_sel;
  logic [SW-1:0] rdata_sel;
  logic [SW-1:0] cmp_x, cmp_y;
  logic          cmp_gt, cmp_eq;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] ia_n, ib_n;
  state_e        merge_st, after_a_st, done_st;

  logic          wr_en, wr_b;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mrg_re;
  logic [AW-1:0] mrg_addr_a, mrg_addr_b;

  assign n_sel     = sel_b_q ? cnt_b_q : cnt_a_q;
  assign rdata_sel = sel_b_q ? b_rdata_i : a_rdata_i;
  assign i_inc     = i_q + CW'(1);

  // shared comparator: merge compares A against B, sort compares entry against key
  assign cmp_x  = (state_q == ST_MRG_CMP) ? a_rdata_i : rdata_sel;
  assign cmp_y  = (state_q == ST_MRG_CMP) ? b_rdata_i : key_q;
  assign cmp_gt = cmp_x > cmp_y;
  assign cmp_eq = cmp_x == cmp_y;

  assign merge_st   = (cnt_a_q == '0 || cnt_b_q == '0) ? ST_FLUSH : ST_MRG_RD;
  assign after_a_st = (cnt_b_q >= Two) ? ST_SORT_KEY : merge_st;
  assign done_st    = sel_b_q ? merge_st : after_a_st;

  always_comb begin
    state_d    = state_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    ovf_d      = ovf_q;
    sel_b_d    = sel_b_q;
    i_d        = i_q;
    j_d        = j_q;
    key_d      = key_q;
    ia_d       = ia_q;
    ib_d       = ib_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    ia_n       = ia_q;
    ib_n       = ib_q;
    wr_en      = 1'b0;
    wr_b       = sel_b_q;
    wr_addr    = j_q;
    wr_data    = key_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    mrg_re     = 1'b0;
    mrg_addr_a = '0;
    mrg_addr_b = '0;
    res_o      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            OP_APPEND_A: begin
              if (cnt_a_q < Cap) begin
                wr_en   = 1'b1;
                wr_b    = 1'b0;
                wr_addr = cnt_a_q[AW-1:0];
                wr_data = in_doc_id_i[SW-1:0];
                cnt_a_d = cnt_a_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_APPEND_B: begin
              if (cnt_b_q < Cap) begin
                wr_en   = 1'b1;
                wr_b    = 1'b1;
                wr_addr = cnt_b_q[AW-1:0];
                wr_data = in_doc_id_i[SW-1:0];
                cnt_b_d = cnt_b_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_INTERSECT: begin
              i_d        = CW'(1);
              pend_vld_d = 1'b0;
              if (cnt_a_q >= Two) begin
                sel_b_d = 1'b0;
                state_d = ST_SORT_KEY;
              end else begin
                sel_b_d = 1'b1;
                state_d = after_a_st;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SORT_KEY: begin
        rd_en   = 1'b1;
        rd_addr = i_q[AW-1:0];
        state_d = ST_SORT_KEYW;
      end

      ST_SORT_KEYW: begin
        key_d   = rdata_sel;
        j_d     = i_q[AW-1:0];
        rd_en   = 1'b1;
        rd_addr = i_q[AW-1:0] - AW'(1);
        state_d = ST_SORT_CMP;
      end

      ST_SORT_CMP: begin
        wr_en = 1'b1;
        if (cmp_gt) begin
          // shift the larger entry up one slot
          wr_data = rdata_sel;
          j_d     = j_q - AW'(1);
          if (j_q != AW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = j_q - AW'(2);
          end else begin
            state_d = ST_SORT_PLACE;
          end
        end else begin
          wr_data = key_q;
          i_d     = i_inc;
          if (i_inc < n_sel) begin
            state_d = ST_SORT_KEY;
          end else begin
            sel_b_d = 1'b1;
            i_d     = CW'(1);
            state_d = done_st;
          end
        end
      end

      ST_SORT_PLACE: begin
        // key reached the bottom of the list
        wr_en   = 1'b1;
        wr_data = key_q;
        i_d     = i_inc;
        if (i_inc < n_sel) begin
          state_d = ST_SORT_KEY;
        end else begin
          sel_b_d = 1'b1;
          i_d     = CW'(1);
          state_d = done_st;
        end
      end

      ST_MRG_RD: begin
        mrg_re  = 1'b1;
        ia_d    = '0;
        ib_d    = '0;
        state_d = ST_MRG_CMP;
      end

      ST_MRG_CMP: begin
        // a match is held back one step so the final one can carry last
        if (!(cmp_eq && pend_vld_q && !out_free_i)) begin
          if (cmp_eq) begin
            if (pend_vld_q) begin
              res_o.valid      = 1'b1;
              res_o.match_id   = DOC_ID_W'(pend_id_q);
              res_o.overflowed = ovf_q;
            end
            pend_vld_d = 1'b1;
            pend_id_d  = a_rdata_i;
            ia_n       = ia_q + CW'(1);
            ib_n       = ib_q + CW'(1);
          end else if (cmp_gt) begin
            ib_n = ib_q + CW'(1);
          end else begin
            ia_n = ia_q + CW'(1);
          end
          ia_d = ia_n;
          ib_d = ib_n;
          if (ia_n < cnt_a_q && ib_n < cnt_b_q) begin
            mrg_re     = 1'b1;
            mrg_addr_a = ia_n[AW-1:0];
            mrg_addr_b = ib_n[AW-1:0];
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free_i) begin
          res_o.valid      = 1'b1;
          res_o.match_id   = pend_vld_q ? DOC_ID_W'(pend_id_q) : '0;
          res_o.is_empty   = !pend_vld_q;
          res_o.last       = 1'b1;
          res_o.overflowed = ovf_q;
          cnt_a_d          = '0;
          cnt_b_d          = '0;
          ovf_d            = 1'b0;
          pend_vld_d       = 1'b0;
          state_d          = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  assign a_we_o    = wr_en && !wr_b;
  assign b_we_o    = wr_en && wr_b;
  assign a_waddr_o = wr_addr;
  assign b_waddr_o = wr_addr;
  assign a_wdata_o = wr_data;
  assign b_wdata_o = wr_data;
  assign a_re_o    = (rd_en && !sel_b_q) || mrg_re;
  assign b_re_o    = (rd_en && sel_b_q) || mrg_re;
  assign a_raddr_o = mrg_re ? mrg_addr_a : rd_addr;
  assign b_raddr_o = mrg_re ? mrg_addr_b : rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      ovf_q      <= 1'b0;
      sel_b_q    <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      key_q      <= '0;
      ia_q       <= '0;
      ib_q       <= '0;
      pend_vld_q <= 1'b0;
      pend_id_q  <= '0;
    end else begin
      state_q    <= state_d;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      ovf_q      <= ovf_d;
      sel_b_q    <= sel_b_d;
      i_q        <= i_d;
      j_q        <= j_d;
      key_q      <= key_d;
      ia_q       <= ia_d;
      ib_q       <= ib_d;
      pend_vld_q <= pend_vld_d;
      pend_id_q  <= pend_id_d;
    end
  end

  `PLI_ASSERT_IMPL(a_push_needs_slot, clk_i, rst_ni, res_o.valid, out_free_i)
  `PLI_ASSERT_IMPL(a_counts_in_range, clk_i, rst_ni, 1'b1,
                   cnt_a_q <= Cap && cnt_b_q <= Cap)
  `PLI_ASSERT_IMPL(a_merge_idx_valid, clk_i, rst_ni, state_q == ST_MRG_CMP,
                   ia_q < cnt_a_q && ib_q < cnt_b_q)
  `PLI_ASSERT_IMPL(a_sort_j_not_above_i, clk_i, rst_ni, state_q == ST_SORT_CMP,
                   CW'(j_q) <= i_q)
  `PLI_ASSERT_NEXT(a_flush_clears, clk_i, rst_ni, state_q == ST_FLUSH && out_free_i,
                   cnt_a_q == '0 && cnt_b_q == '0 && !ovf_q)

endmodule

`default_nettype wire

### rtl/posting_list_intersection.sv
// ----------------------------------------------------------------------------
// posting_list_intersection
// Appends may arrive back to back.
// Intersect: each list of n >= 2 entries is insertion sorted in place, then
// the merge issues result beats as matches are found; a full output register
// stalls the merge.
// Input ready returns the cycle after the last beat loads the output register.
// Reset clears the counts, the overflow flag and the output valid; the list
// stores are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module posting_list_intersection #(
  parameter int LIST_CAPACITY = pli_pkg::LIST_CAPACITY_DEF,
  parameter int ID_WIDTH      = pli_pkg::ID_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pli_in_if.sink    in_i,
  pli_out_if.source out_o
);
  import pli_pkg::*;

  localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int SW = (ID_WIDTH < DOC_ID_W) ? ID_WIDTH : DOC_ID_W;

  pli_res_t            res;
  logic                out_free;
  logic                out_vld_q;
  logic [DOC_ID_W-1:0] out_id_q;
  logic                out_empty_q;
  logic                out_last_q;
  logic                out_ovf_q;

  logic          a_we, b_we, a_re, b_re;
  logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [SW-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

  pli_seq #(
    .LIST_CAPACITY (LIST_CAPACITY),
    .ID_WIDTH      (ID_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_doc_id_i (in_i.doc_id),
    .in_ready_o  (in_i.ready),
    .out_free_i  (out_free),
    .res_o       (res),
    .a_we_o      (a_we),
    .a_waddr_o   (a_waddr),
    .a_wdata_o   (a_wdata),
    .a_re_o      (a_re),
    .a_raddr_o   (a_raddr),
    .a_rdata_i   (a_rdata),
    .b_we_o      (b_we),
    .b_waddr_o   (b_waddr),
    .b_wdata_o   (b_wdata),
    .b_re_o      (b_re),
    .b_raddr_o   (b_raddr),
    .b_rdata_i   (b_rdata)
  );

  pli_list_ram #(
    .DEPTH (LIST_CAPACITY),
    .WIDTH (SW)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  pli_list_ram #(
    .DEPTH (LIST_CAPACITY),
    .WIDTH (SW)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // output register: a new beat may load in the cycle the old one leaves
  assign out_free = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res.valid) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_id_q    <= res.match_id;
      out_empty_q <= res.is_empty;
      out_last_q  <= res.last;
      out_ovf_q   <= res.overflowed;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.match_id   = out_id_q;
  assign out_o.is_empty   = out_empty_q;
  assign out_o.last       = out_last_q;
  assign out_o.overflowed = out_ovf_q;

endmodule

`default_nettype wire

### test/posting_list_intersection_tb.sv
// ----------------------------------------------------------------------------
// posting_list_intersection_tb
// Self-checking bench for the posting list intersection block. A short table
// of directed beats is followed by random batches of appends that each end
// in an intersect. Every accepted input beat runs through a behavioral
// multiset intersection, and every result beat is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module posting_list_intersection_tb;
  import pli_pkg::*;

  localparam int              LIST_CAP     = LIST_CAPACITY_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED    = OP_W'(3);
  localparam int              IDLE_PCT     = 20;
  localparam int              HOLD_CYCLES  = 400;
  localparam int              DRAIN_CYCLES = 100;
  localparam int              ITEM_TARGET  = 210;
  localparam int              LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [DOC_ID_W-1:0] match_id;
    logic                is_empty;
    logic                last;
    logic                overflowed;
  } match_beat_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [DOC_ID_W-1:0] doc_id;
    logic                typed;
    match_beat_t         want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pli_in_if  in_ch ();
  pli_out_if out_ch ();

  posting_list_intersection u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // shadow copy of both lists
  logic [DOC_ID_W-1:0] shadow_ids [2][LIST_CAP];
  int                  shadow_len [2];
  logic                shadow_dropped;

  match_beat_t predicted [$];
  match_beat_t pending_matches [$];
  dir_row_t    dir_rows [$];

  int  failures     = 0;
  int  n_items      = 0;
  int  n_intersects = 0;
  int  n_checked    = 0;
  bit  calm         = 1'b0;
  bit  hold_armed   = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("tb: failure");
    $finish;
  end

  function automatic match_beat_t beat(input logic [DOC_ID_W-1:0] id, input logic empty,
                                       input logic lst, input logic ovf);
    match_beat_t b;
    b.match_id   = id;
    b.is_empty   = empty;
    b.last       = lst;
    b.overflowed = ovf;
    return b;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [DOC_ID_W-1:0] id,
                         input logic typed, input match_beat_t want);
    dir_row_t r;
    r.op     = op;
    r.doc_id = id;
    r.typed  = typed;
    r.want   = want;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Update the shadow lists for one accepted beat; an intersect fills
  // predicted with the ascending multiset intersection.
  task automatic model_item(input logic [OP_W-1:0] op, input logic [DOC_ID_W-1:0] id);
    logic [DOC_ID_W-1:0] work [2][LIST_CAP];
    logic [DOC_ID_W-1:0] key;
    int                  l, i, j, ia, ib, sel;
    match_beat_t         b;
    predicted.delete();
    case (op)
      OP_APPEND_A, OP_APPEND_B: begin
        sel = (op == OP_APPEND_B) ? 1 : 0;
        if (shadow_len[sel] < LIST_CAP) begin
          shadow_ids[sel][shadow_len[sel]] = id;
          shadow_len[sel]++;
        end else begin
          shadow_dropped = 1'b1;
        end
      end
      OP_INTERSECT: begin
        for (l = 0; l < 2; l++) begin
          for (i = 0; i < shadow_len[l]; i++) begin
            key = shadow_ids[l][i];
            j = i;
            while (j > 0 && work[l][j-1] > key) begin
              work[l][j] = work[l][j-1];
              j--;
            end
            work[l][j] = key;
          end
        end
        ia = 0;
        ib = 0;
        while (ia < shadow_len[0] && ib < shadow_len[1]) begin
          if (work[0][ia] == work[1][ib]) begin
            predicted.insert(predicted.size(),
                             beat(work[0][ia], 1'b0, 1'b0, shadow_dropped));
            ia++;
            ib++;
          end else if (work[0][ia] < work[1][ib]) begin
            ia++;
          end else begin
            ib++;
          end
        end
        if (predicted.size() == 0) begin
          predicted.insert(0, beat('0, 1'b1, 1'b1, shadow_dropped));
        end else begin
          b = predicted[predicted.size() - 1];
          b.last = 1'b1;
          predicted[predicted.size() - 1] = b;
        end
        shadow_len[0] = 0;
        shadow_len[1] = 0;
        shadow_dropped = 1'b0;
        n_intersects++;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [DOC_ID_W-1:0] id,
                           input logic typed, input match_beat_t want);
    int k;
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.doc_id <= id;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    n_items++;
    model_item(op, id);
    if (typed) begin
      pending_matches.insert(pending_matches.size(), want);
    end else begin
      for (k = 0; k < predicted.size(); k++) begin
        pending_matches.insert(pending_matches.size(), predicted[k]);
      end
    end
  endtask

  // Appends to both lists in random interleaving, mostly drawn from a small
  // pool so that ids repeat, then one intersect.
  task automatic run_batch(input int len_a, input int len_b, input int pool_n);
    logic [DOC_ID_W-1:0] pool [8];
    logic [OP_W-1:0]     op;
    logic [DOC_ID_W-1:0] id;
    int                  i, left_a, left_b, pick;
    for (i = 0; i < pool_n; i++) begin
      pick = $urandom_range(9);
      pool[i] = (pick == 0) ? '0 : (pick == 1) ? '1 : DOC_ID_W'($urandom);
    end
    left_a = len_a;
    left_b = len_b;
    while (left_a + left_b > 0) begin
      if ($urandom_range(99) < 6) send_item(OP_UNUSED, $urandom, 1'b0, '0);
      if (left_b == 0 || (left_a != 0 && $urandom_range(1) == 0)) begin
        op = OP_APPEND_A;
        left_a--;
      end else begin
        op = OP_APPEND_B;
        left_b--;
      end
      id = ($urandom_range(99) < 75) ? pool[$urandom_range(pool_n - 1)] : DOC_ID_W'($urandom);
      send_item(op, id, 1'b0, '0);
    end
    send_item(OP_INTERSECT, $urandom, 1'b0, '0);
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    match_beat_t exp_b;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_matches.size() == 0) begin
        $error("unexpected result beat: match_id %h", out_ch.match_id);
        failures++;
      end else begin
        exp_b = pending_matches[0];
        pending_matches.delete(0);
        n_checked++;
        if (out_ch.match_id !== exp_b.match_id) begin
          $error("match_id: expected %h, got %h", exp_b.match_id, out_ch.match_id);
          failures++;
        end
        if (out_ch.is_empty !== exp_b.is_empty) begin
          $error("is_empty: expected %b, got %b", exp_b.is_empty, out_ch.is_empty);
          failures++;
        end
        if (out_ch.last !== exp_b.last) begin
          $error("last: expected %b, got %b", exp_b.last, out_ch.last);
          failures++;
        end
        if (out_ch.overflowed !== exp_b.overflowed) begin
          $error("overflowed: expected %b, got %b", exp_b.overflowed, out_ch.overflowed);
          failures++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_APPEND_A;
    in_ch.doc_id  = '0;
    shadow_len[0] = 0;
    shadow_len[1] = 0;
    shadow_dropped = 1'b0;

    // empty after reset, extremes, unused op, duplicates, disjoint, one-sided
    add_row(OP_INTERSECT, '0, 1'b1, beat('0, 1'b1, 1'b1, 1'b0));
    add_row(OP_UNUSED,    '1, 1'b0, '0);
    add_row(OP_APPEND_A,  '1, 1'b0, '0);
    add_row(OP_APPEND_B,  '1, 1'b0, '0);
    add_row(OP_INTERSECT, '1, 1'b1, beat('1, 1'b0, 1'b1, 1'b0));
    add_row(OP_APPEND_A,  '0, 1'b0, '0);
    add_row(OP_APPEND_B,  '0, 1'b0, '0);
    add_row(OP_INTERSECT, '0, 1'b1, beat('0, 1'b0, 1'b1, 1'b0));
    add_row(OP_APPEND_A,  7, 1'b0, '0);
    add_row(OP_APPEND_A,  3, 1'b0, '0);
    add_row(OP_APPEND_A,  7, 1'b0, '0);
    add_row(OP_APPEND_B,  7, 1'b0, '0);
    add_row(OP_APPEND_B,  9, 1'b0, '0);
    add_row(OP_APPEND_B,  7, 1'b0, '0);
    add_row(OP_APPEND_B,  3, 1'b0, '0);
    add_row(OP_INTERSECT, 32'h5a5a_a5a5, 1'b0, '0);
    add_row(OP_APPEND_A,  1, 1'b0, '0);
    add_row(OP_APPEND_B,  2, 1'b0, '0);
    add_row(OP_INTERSECT, '0, 1'b1, beat('0, 1'b1, 1'b1, 1'b0));
    add_row(OP_APPEND_A,  8, 1'b0, '0);
    add_row(OP_INTERSECT, '0, 1'b1, beat('0, 1'b1, 1'b1, 1'b0));
    add_row(OP_UNUSED,    '0, 1'b0, '0);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].doc_id, dir_rows[i].typed, dir_rows[i].want);
    end

    // heavy matches while the result side holds off
    hold_armed = 1'b1;
    run_batch(8, 8, 3);
    // both lists overflow, no idling on either side
    calm = 1'b1;
    run_batch(LIST_CAP + 1, LIST_CAP + 2, 4);
    calm = 1'b0;
    while (n_items < ITEM_TARGET) begin
      run_batch($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(1, 6));
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d input beats, %0d intersections, %0d result beats checked",
             n_items, n_intersects, n_checked);
    $display("tb: covered empty and full lists, overflow on both lists, duplicates");
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/pli_pkg.sv
rtl/pli_in_if.sv
rtl/pli_out_if.sv
rtl/pli_list_ram.sv
rtl/pli_seq.sv
rtl/posting_list_intersection.sv
test/posting_list_intersection_tb.sv
